/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 4;
    localparam int ATTR_W   = 2 * COLOUR_W;
    localparam int CELL_W   = ATTR_W + CHAR_W;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int LIN_W    = 11;
    localparam int ADDR_IN_W = 11;

    // tab stops
    localparam int TAB_STEP = 4;
    localparam int TAB_W    = $clog2(TAB_STEP);

    // character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

    // register reset values
    localparam logic [COLOUR_W-1:0] RESET_FG = 4'hF;
    localparam logic [COLOUR_W-1:0] RESET_BG = 4'h0;

    // configuration port
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic {
        REG_DEFAULT_FG = 1'b0,
        REG_BACKGROUND = 1'b1
    } reg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_EOS   = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_CHAR      = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_RETURN    = 3'd2,
        OP_TAB       = 3'd3,
        OP_BACKSPACE = 3'd4,
        OP_READ      = 3'd5,
        OP_EOS       = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [ADDR_W-1:0] addr;
        logic              addr_ok;
    } cmd_t;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/tcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    input  wire logic [COLOUR_W-1:0]  s_fore_colour,
    input  wire logic [ADDR_IN_W-1:0] s_cell_address,
    // queue side
    input  wire q_status_t            q_stat,
    input  wire logic                 init_busy,
    output logic                      push,
    output cmd_t                      push_cmd
);

    logic [COLOUR_W-1:0] fg_reg;
    logic [COLOUR_W-1:0] bg_reg;
    reg_idx_t            reg_idx;
    logic                cfg_write;
    logic [COLOUR_W-1:0] fg_sel;

    assign reg_idx   = reg_idx_t'(paddr[REG_IDX_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_DEFAULT_FG: fg_reg <= pwdata[COLOUR_W-1:0];
                REG_BACKGROUND: bg_reg <= pwdata[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_DEFAULT_FG: prdata = PDATA_W'(fg_reg);
            REG_BACKGROUND: prdata = PDATA_W'(bg_reg);
            default:        prdata = '0;
        endcase
    end

    // transaction acceptance
    assign s_ready = !q_stat.full && !init_busy;
    assign push    = s_valid && s_ready;

    // classify the item
    assign fg_sel = (s_fore_colour != '0) ? s_fore_colour : fg_reg;

    always_comb begin
        push_cmd.ch      = s_char_code;
        push_cmd.attr    = {bg_reg, fg_sel};
        push_cmd.addr_ok = (s_cell_address < ADDR_IN_W'(CELL_COUNT));
        push_cmd.addr    = push_cmd.addr_ok ? ADDR_W'(s_cell_address) : '0;
        case (func_t'(s_func))
            FUNC_PUT: begin
                case (s_char_code)
                    CH_NEWLINE:   push_cmd.op = OP_NEWLINE;
                    CH_RETURN:    push_cmd.op = OP_RETURN;
                    CH_TAB:       push_cmd.op = OP_TAB;
                    CH_BACKSPACE: push_cmd.op = OP_BACKSPACE;
                    default:      push_cmd.op = OP_CHAR;
                endcase
            end
            FUNC_READ: push_cmd.op = OP_READ;
            FUNC_EOS:  push_cmd.op = OP_EOS;
            FUNC_CLEAR: begin
                push_cmd.op   = OP_CLEAR;
                push_cmd.attr = {bg_reg, fg_reg};
            end
            default: push_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tcw_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire cmd_t      push_cmd,
    input  wire logic      pop,
    output cmd_t           pop_cmd,
    output q_status_t      q_stat
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_cmd      = entries_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_back
    import tcw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // queue side
    input  wire q_status_t   q_stat,
    input  wire cmd_t        pop_cmd,
    output logic             pop,
    output logic             init_busy,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [COL_W-1:0]  m_cursor_column,
    output logic [ROW_W-1:0]  m_cursor_row,
    output logic [LIN_W-1:0]  m_cursor_linear,
    output logic [CELL_W-1:0] m_cell_value,
    output logic              m_did_scroll
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FILL   = 6'b100000
    } state_t;

    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLUMNS_A  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_COUNT = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [TAB_W-1:0]  TAB_LAST   = TAB_W'(TAB_STEP - 1);
    localparam logic [CELL_W-1:0] RESET_FILL = {RESET_BG, RESET_FG, CH_BLANK};

    // screen store
    logic [CELL_W-1:0] screen_mem [CELL_COUNT];

    state_t            state_reg,     state_next;
    cmd_t              cmd_reg,       cmd_next;
    logic [COL_W-1:0]  col_reg,       col_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [ADDR_W-1:0] cnt_reg,       cnt_next;
    logic              scroll_reg,    scroll_next;
    logic              init_reg,      init_next;
    logic [CELL_W-1:0] fill_data_reg, fill_data_next;
    logic              wr_pend_reg,   wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg,   wr_addr_next;
    logic              wr_blank_reg,  wr_blank_next;
    logic [CELL_W-1:0] rd_data_reg;
    logic              m_valid_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [LIN_W-1:0]  m_linear_reg;
    logic [CELL_W-1:0] m_cell_reg;
    logic              m_scroll_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              finish;
    logic [LIN_W-1:0]  fin_linear;
    logic [CELL_W-1:0] fin_cell;

    logic [ADDR_W-1:0] cur_addr;
    logic              at_end;
    logic              on_last_row;
    logic [COL_W-1:0]  eos_col;
    logic [ROW_W-1:0]  eos_row;
    logic [ADDR_W-1:0] eos_addr;
    logic              copy_region;
    logic [CELL_W-1:0] blank_cell;

    // cursor address arithmetic
    assign cur_addr    = ADDR_W'(row_reg) * COLUMNS_A + ADDR_W'(col_reg);
    assign at_end      = (col_reg >= COL_LIMIT);
    assign on_last_row = (row_reg >= LAST_ROW);
    assign eos_col     = at_end ? LAST_COL : col_reg;
    assign eos_row     = (row_reg > LAST_ROW) ? LAST_ROW : row_reg;
    assign eos_addr    = ADDR_W'(eos_row) * COLUMNS_A + ADDR_W'(eos_col);
    assign copy_region = (cnt_reg < COPY_COUNT);
    assign blank_cell  = {cmd_reg.attr, CH_BLANK};

    assign init_busy = init_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        scroll_next    = scroll_reg;
        init_next      = init_reg;
        fill_data_next = fill_data_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_blank_next  = wr_blank_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr;
        mem_wdata      = blank_cell;
        mem_raddr      = cmd_reg.addr;
        pop            = 1'b0;
        finish         = 1'b0;
        fin_linear     = '0;
        fin_cell       = '0;

        case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty && (!m_valid_reg || m_ready)) begin
                    pop         = 1'b1;
                    cmd_next    = pop_cmd;
                    scroll_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC: begin
                case (cmd_reg.op)
                    OP_CHAR, OP_NEWLINE, OP_TAB: begin
                        if (cmd_reg.op == OP_NEWLINE || at_end) begin
                            // line break, scroll when already on the bottom row
                            col_next = '0;
                            if (!on_last_row) begin
                                row_next = row_reg + 1'b1;
                                if (cmd_reg.op == OP_NEWLINE) begin
                                    finish = 1'b1;
                                end
                            end else begin
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                                state_next  = S_SCROLL;
                            end
                        end else if (cmd_reg.op == OP_CHAR) begin
                            mem_we    = 1'b1;
                            mem_wdata = {cmd_reg.attr, cmd_reg.ch};
                            col_next  = col_reg + 1'b1;
                            finish    = 1'b1;
                        end else begin
                            // one blank per cycle up to the next tab stop
                            mem_we   = 1'b1;
                            col_next = col_reg + 1'b1;
                            if (col_reg[TAB_W-1:0] == TAB_LAST || col_reg == LAST_COL) begin
                                finish = 1'b1;
                            end
                        end
                    end
                    OP_RETURN: begin
                        col_next = '0;
                        finish   = 1'b1;
                    end
                    OP_BACKSPACE: begin
                        // the cell before the cursor is always cur_addr - 1
                        if (col_reg != '0 || row_reg != '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr - 1'b1;
                            if (col_reg != '0) begin
                                col_next = col_reg - 1'b1;
                            end else begin
                                row_next = row_reg - 1'b1;
                                col_next = LAST_COL;
                            end
                        end
                        finish = 1'b1;
                    end
                    OP_READ: begin
                        state_next = S_READ;
                    end
                    OP_EOS: begin
                        col_next   = eos_col;
                        row_next   = eos_row;
                        fin_linear = LIN_W'(eos_addr);
                        finish     = 1'b1;
                    end
                    OP_CLEAR: begin
                        col_next       = '0;
                        row_next       = '0;
                        fill_data_next = blank_cell;
                        cnt_next       = '0;
                        init_next      = 1'b0;
                        state_next     = S_FILL;
                    end
                    default: finish = 1'b1;
                endcase
            end

            S_READ: begin
                fin_cell = cmd_reg.addr_ok ? rd_data_reg : '0;
                finish   = 1'b1;
            end

            S_SCROLL: begin
                // read one row ahead, write back in the next cycle
                mem_raddr     = copy_region ? cnt_reg + COLUMNS_A : cnt_reg;
                mem_we        = wr_pend_reg;
                mem_waddr     = wr_addr_reg;
                mem_wdata     = wr_blank_reg ? blank_cell : rd_data_reg;
                wr_pend_next  = 1'b1;
                wr_addr_next  = cnt_reg;
                wr_blank_next = !copy_region;
                if (cnt_reg == LAST_CELL) begin
                    state_next = S_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DRAIN: begin
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = wr_blank_reg ? blank_cell : rd_data_reg;
                if (cmd_reg.op == OP_NEWLINE) begin
                    finish = 1'b1;
                end else begin
                    state_next = S_EXEC;
                end
            end

            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = fill_data_reg;
                if (cnt_reg == LAST_CELL) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (finish) begin
            state_next = S_IDLE;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            scroll_reg    <= 1'b0;
            init_reg      <= 1'b1;
            fill_data_reg <= RESET_FILL;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            scroll_reg    <= scroll_next;
            init_reg      <= init_next;
            fill_data_reg <= fill_data_next;
            wr_pend_reg   <= wr_pend_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        wr_addr_reg  <= wr_addr_next;
        wr_blank_reg <= wr_blank_next;
        if (finish) begin
            m_col_reg    <= col_next;
            m_row_reg    <= row_next;
            m_linear_reg <= fin_linear;
            m_cell_reg   <= fin_cell;
            m_scroll_reg <= scroll_next;
        end
    end

    // screen store ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[mem_raddr];
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_column = m_col_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_cursor_linear = m_linear_reg;
    assign m_cell_value    = m_cell_reg;
    assign m_did_scroll    = m_scroll_reg;

endmodule

`default_nettype wire

/* rtl/text_console_writer.sv */
// a wrap at the right margin adds a line break before the character, a scroll adds a pass that
// moves the rows up and blanks the bottom row, and a clear runs a fill pass over all cells.
// the back-end sequencer pops the next queued command only after the previous one has finished
// and the result register is free; up to QUEUE_DEPTH commands can wait in the queue meanwhile.
// reset: synchronous active-low; then a clearing pass over all COLUMNS*ROWS cells blanks the store.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [CHAR_W-1:0]    s_char_code,
    input  wire logic [COLOUR_W-1:0]  s_fore_colour,
    input  wire logic [ADDR_IN_W-1:0] s_cell_address,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [COL_W-1:0]          m_cursor_column,
    output logic [ROW_W-1:0]          m_cursor_row,
    output logic [LIN_W-1:0]          m_cursor_linear,
    output logic [CELL_W-1:0]         m_cell_value,
    output logic                      m_did_scroll
);

    q_status_t q_stat;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    logic      init_busy;

    // accept and classify
    tcw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_char_code    (s_char_code),
        .s_fore_colour  (s_fore_colour),
        .s_cell_address (s_cell_address),
        .q_stat         (q_stat),
        .init_busy      (init_busy),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // command queue
    tcw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // execution and screen store
    tcw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .pop_cmd         (pop_cmd),
        .pop             (pop),
        .init_busy       (init_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_column (m_cursor_column),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_value    (m_cell_value),
        .m_did_scroll    (m_did_scroll)
    );

    // no transaction is taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn) init_busy |-> !s_ready)
        else $error("input accepted during clearing pass");

    // the queue is never pushed when full nor popped when empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full) && !(pop && q_stat.empty))
        else $error("queue overflow or underflow");

    // reported cursor stays on or just past the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_row < ROW_W'(ROWS)) && (m_cursor_column <= COL_W'(COLUMNS)))
        else $error("cursor out of range");

    // a scroll always leaves the cursor on the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_did_scroll) |-> (m_cursor_row == ROW_W'(ROWS - 1)))
        else $error("scroll without cursor on the bottom row");

endmodule

`default_nettype wire
